[rtl/cfb_pkg.sv]
// ----------------------------------------------------------------------------
// cfb_pkg: shared types, constants and CRC step for the frame builder
// Holds the frame layout constants, the request record that travels from
// the front end to the serializer, and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

    localparam int MaxFrame      = 128;
    localparam int FrameOverhead = 10;
    localparam int MaxPayload    = MaxFrame - FrameOverhead;

    localparam int LenW  = 7;
    localparam int ByteW = 8;
    localparam int SeqW  = 16;
    localparam int CrcW  = 16;

    localparam logic [ByteW-1:0] MagicA   = 8'hAA;
    localparam logic [ByteW-1:0] MagicB   = 8'h55;
    localparam logic [ByteW-1:0] ProtoVer = 8'h01;
    localparam logic [CrcW-1:0]  CrcInit  = 16'hFFFF;
    localparam logic [CrcW-1:0]  CrcPoly  = 16'h1021;

    // Request depth between front end and serializer
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    // One request: either a frame start (header, optional first byte) or
    // a payload byte. last marks the byte after which the CRC goes out.
    typedef struct packed {
        logic              start;
        logic              has_data;
        logic              last;
        logic [ByteW-1:0]  msg_type;
        logic [SeqW-1:0]   seq;
        logic [LenW-1:0]   len;
        logic [ByteW-1:0]  data;
    } t_cmd;

    function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
        logic [CrcW-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < ByteW; i++) begin
            if (c[CrcW-1]) begin
                c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                c = {c[CrcW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/cfb_front.sv]
// ----------------------------------------------------------------------------
// cfb_front: input classifier
// Accepts input items, tracks frame membership, sequence number and bytes
// remaining, drops stray items and queues start and payload requests.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic                      i_start_req,
    input  wire logic [cfb_pkg::ByteW-1:0] i_msg_type,
    input  wire logic [cfb_pkg::LenW-1:0]  i_payload_len,
    input  wire logic [cfb_pkg::ByteW-1:0] i_data_byte,
    output logic                           o_push,
    output cfb_pkg::t_cmd                  o_cmd
);
    import cfb_pkg::*;

    logic            r_in_frame, n_in_frame;
    logic [LenW-1:0] r_left, n_left;
    logic [SeqW-1:0] r_seq, n_seq;
    logic [LenW-1:0] len_sat;

    always_comb begin
        if (int'(i_payload_len) > MaxPayload) begin
            len_sat = LenW'(MaxPayload);
        end else begin
            len_sat = i_payload_len;
        end
    end

    always_comb begin
        n_in_frame      = r_in_frame;
        n_left          = r_left;
        n_seq           = r_seq;
        o_push          = 1'b0;
        o_cmd.start     = i_start_req;
        o_cmd.has_data  = 1'b1;
        o_cmd.last      = 1'b0;
        o_cmd.msg_type  = i_msg_type;
        o_cmd.seq       = r_seq;
        o_cmd.len       = len_sat;
        o_cmd.data      = i_data_byte;
        if (i_accept) begin
            if (i_start_req) begin
                o_push         = 1'b1;
                o_cmd.has_data = (len_sat != '0);
                o_cmd.last     = (len_sat == LenW'(1));
                n_seq          = r_seq + SeqW'(1);
                n_in_frame     = (len_sat > LenW'(1));
                n_left         = (len_sat != '0) ? len_sat - LenW'(1) : '0;
            end else if (r_in_frame) begin
                o_push     = 1'b1;
                o_cmd.last = (r_left == LenW'(1));
                n_left     = r_left - LenW'(1);
                n_in_frame = (r_left != LenW'(1));
            end
            // otherwise drop the stray item
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_left     <= '0;
            r_seq      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_left     <= n_left;
            r_seq      <= n_seq;
        end
    end

endmodule

`default_nettype wire

[rtl/cfb_queue.sv]
// ----------------------------------------------------------------------------
// cfb_queue: request queue
// Short FIFO that decouples the classifier from the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  cfb_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_nonempty,
    output cfb_pkg::t_cmd      o_cmd
);
    import cfb_pkg::*;

    t_cmd             r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCntW-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full     = (r_count == QCntW'(QueueDepth));
    assign o_nonempty = (r_count != '0);
    assign o_cmd      = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPtrW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCntW'(1);
                2'b01:   r_count <= r_count - QCntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/cfb_back.sv]
// ----------------------------------------------------------------------------
// cfb_back: frame serializer
// Emits header, payload and CRC bytes one per cycle when i_ready does not stall the
// registered output stage, updating the running CRC as bytes go out.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cmd_valid,
    input  cfb_pkg::t_cmd                  i_cmd,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [cfb_pkg::ByteW-1:0]      o_out_byte,
    output logic                           o_frame_end
);
    import cfb_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_H1    = 11'b000_0000_0010,
        S_H2    = 11'b000_0000_0100,
        S_H3    = 11'b000_0000_1000,
        S_H4    = 11'b000_0001_0000,
        S_H5    = 11'b000_0010_0000,
        S_H6    = 11'b000_0100_0000,
        S_H7    = 11'b000_1000_0000,
        S_DATA  = 11'b001_0000_0000,
        S_CRCLO = 11'b010_0000_0000,
        S_CRCHI = 11'b100_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CrcW-1:0]  r_crc, n_crc, crc_base;
    logic             r_valid;
    logic [ByteW-1:0] r_byte;
    logic             r_end;
    logic             emit, feed, pop, fend, adv, go;
    logic [ByteW-1:0] ebyte;
    logic [SeqW-1:0]  len16;

    assign adv   = !r_valid || i_ready;
    assign len16 = SeqW'(i_cmd.len);

    always_comb begin
        n_state  = r_state;
        emit     = 1'b1;
        feed     = 1'b0;
        pop      = 1'b0;
        fend     = 1'b0;
        ebyte    = '0;
        crc_base = r_crc;
        unique case (r_state)
            S_IDLE: begin
                emit = i_cmd_valid;
                if (i_cmd.start) begin
                    ebyte   = MagicA;
                    n_state = S_H1;
                end else begin
                    ebyte   = i_cmd.data;
                    feed    = 1'b1;
                    pop     = 1'b1;
                    n_state = i_cmd.last ? S_CRCLO : S_IDLE;
                end
            end
            S_H1: begin
                ebyte   = MagicB;
                n_state = S_H2;
            end
            S_H2: begin
                // restart the CRC at the version byte
                ebyte    = ProtoVer;
                feed     = 1'b1;
                crc_base = CrcInit;
                n_state  = S_H3;
            end
            S_H3: begin
                ebyte   = i_cmd.msg_type;
                feed    = 1'b1;
                n_state = S_H4;
            end
            S_H4: begin
                ebyte   = i_cmd.seq[7:0];
                feed    = 1'b1;
                n_state = S_H5;
            end
            S_H5: begin
                ebyte   = i_cmd.seq[15:8];
                feed    = 1'b1;
                n_state = S_H6;
            end
            S_H6: begin
                ebyte   = len16[7:0];
                feed    = 1'b1;
                n_state = S_H7;
            end
            S_H7: begin
                ebyte = len16[15:8];
                feed  = 1'b1;
                if (i_cmd.has_data) begin
                    n_state = S_DATA;
                end else begin
                    pop     = 1'b1;
                    n_state = S_CRCLO;
                end
            end
            S_DATA: begin
                ebyte   = i_cmd.data;
                feed    = 1'b1;
                pop     = 1'b1;
                n_state = i_cmd.last ? S_CRCLO : S_IDLE;
            end
            S_CRCLO: begin
                ebyte   = r_crc[7:0];
                n_state = S_CRCHI;
            end
            S_CRCHI: begin
                ebyte   = r_crc[15:8];
                fend    = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                emit    = 1'b0;
                n_state = S_IDLE;
            end
        endcase
        n_crc = feed ? crc_feed(crc_base, ebyte) : r_crc;
    end

    assign go      = emit && adv;
    assign o_pop   = pop && go;
    assign o_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_crc   <= CrcInit;
            r_valid <= 1'b0;
        end else begin
            if (go) begin
                r_state <= n_state;
                r_crc   <= n_crc;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_byte <= ebyte;
            r_end  <= fend;
        end
    end

endmodule

`default_nettype wire

[rtl/crc16_frame_builder_core.sv]
// A payload byte passes through the request queue and the serializer output register.
// Bytes leave at one per cycle while i_ready is high; payload items enter at one per
// cycle while o_ready is high. A start request occupies the serializer for its header
// bytes; a final payload byte adds the CRC. A 4-entry queue and o_ready absorb it.
// Reset (synchronous, active low) clears sequence, frame and queue state; no
// clearing pass, the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// crc16_frame_builder_core: CRC-16 framed byte serializer
// Front end classifies input items and queues requests; the back end
// serializes header, payload and CRC bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_builder_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_start_req,
    input  wire logic [cfb_pkg::ByteW-1:0] i_msg_type,
    input  wire logic [cfb_pkg::LenW-1:0]  i_payload_len,
    input  wire logic [cfb_pkg::ByteW-1:0] i_data_byte,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [cfb_pkg::ByteW-1:0]      o_out_byte,
    output logic                           o_frame_end
);
    import cfb_pkg::*;

    logic push, pop, q_full, q_nonempty;
    t_cmd push_cmd, head_cmd;

    assign o_ready = !q_full;

    cfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (i_valid && o_ready),
        .i_start_req   (i_start_req),
        .i_msg_type    (i_msg_type),
        .i_payload_len (i_payload_len),
        .i_data_byte   (i_data_byte),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    cfb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (push_cmd),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_cmd      (head_cmd)
    );

    cfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_nonempty),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire

[sim/tb_crc16_frame_builder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_frame_builder_core: self-checking bench for the CRC-16 framer
// Drives a table of directed requests and then random frames, some of them
// truncated or surrounded by stray bytes, through the valid/ready input
// with random bursts and gaps. Every output byte is compared against a
// serializer model kept here, while the output side stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb_crc16_frame_builder_core;

    import cfb_pkg::*;

    localparam int ItemTarget    = 400;
    localparam int WatchdogLimit = 2000;
    localparam int DirRows       = 18;

    typedef struct packed {
        logic       b;
        logic [7:0] data;
    } t_frame_byte;

    // One directed request; n_res is the expected output byte count, used when chk_n is set
    typedef struct packed {
        logic       start;
        logic [7:0] mtype;
        logic [6:0] len;
        logic [7:0] data;
        logic       chk_n;
        logic [3:0] n_res;
    } t_dir_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  i_start_req   = 1'b0;
    logic [ByteW-1:0]      i_msg_type    = '0;
    logic [LenW-1:0]       i_payload_len = '0;
    logic [ByteW-1:0]      i_data_byte   = '0;
    logic                  i_ready       = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic [ByteW-1:0]      o_out_byte;
    logic                  o_frame_end;

    // Serializer model state
    logic [SeqW-1:0]       seq_next    = '0;
    logic [CrcW-1:0]       crc_run     = CrcInit;
    logic [LenW-1:0]       bytes_left  = '0;
    logic                  in_frame    = 1'b0;

    t_frame_byte           frame_bytes_q [$];

    int burst_left    = 0;
    int busy_items    = 0;
    int frames_opened = 0;
    int frames_cut    = 0;
    int dropped_items = 0;
    int longest_len   = 0;
    int bytes_checked = 0;
    int out_errors    = 0;
    int tbl_errors    = 0;
    int idle_cycles   = 0;
    int hold_cnt      = 0;
    int hold_step     = 0;
    logic [31:0] rx_cyc = '0;

    t_dir_row dir_rows [DirRows] = '{
        '{1'b0, 8'hFF, 7'h7F, 8'hFF, 1'b1, 4'd0},   // stray byte right after reset
        '{1'b1, 8'h00, 7'h00, 8'h00, 1'b1, 4'd10},  // empty payload
        '{1'b1, 8'hFF, 7'h01, 8'hFF, 1'b1, 4'd11},  // single payload byte
        '{1'b1, 8'h5A, 7'h7F, 8'h00, 1'b1, 4'd9},   // oversized, saturates
        '{1'b0, 8'h00, 7'h00, 8'h3C, 1'b1, 4'd1},
        '{1'b1, 8'hA5, 7'h76, 8'h80, 1'b1, 4'd9},   // restart mid-frame, exact max length
        '{1'b0, 8'h00, 7'h00, 8'h7F, 1'b1, 4'd1},
        '{1'b1, 8'h81, 7'h03, 8'h01, 1'b1, 4'd9},
        '{1'b0, 8'h00, 7'h00, 8'h02, 1'b1, 4'd1},
        '{1'b0, 8'h00, 7'h00, 8'hFE, 1'b1, 4'd3},   // last byte plus CRC
        '{1'b0, 8'h33, 7'h05, 8'h99, 1'b1, 4'd0},   // stray byte between frames
        '{1'b1, 8'h3C, 7'h77, 8'hAA, 1'b1, 4'd9},   // one above max
        '{1'b1, 8'hC3, 7'h02, 8'h55, 1'b1, 4'd9},
        '{1'b0, 8'hFF, 7'h7F, 8'hAA, 1'b1, 4'd3},   // type and length ignored here
        '{1'b1, 8'h40, 7'h40, 8'h40, 1'b1, 4'd9},
        '{1'b1, 8'h7E, 7'h00, 8'hFF, 1'b1, 4'd10},  // empty frame abandons the open one
        '{1'b1, 8'h01, 7'h02, 8'h00, 1'b0, 4'd0},
        '{1'b0, 8'h80, 7'h01, 8'hC7, 1'b0, 4'd0}
    };

    crc16_frame_builder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_start_req   (i_start_req),
        .i_msg_type    (i_msg_type),
        .i_payload_len (i_payload_len),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_frame_end   (o_frame_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // CRC-16/CCITT-FALSE, one input bit at a time
    function automatic logic [CrcW-1:0] crc_ccitt_byte(input logic [CrcW-1:0] crc,
                                                       input logic [ByteW-1:0] d);
        logic [CrcW-1:0] r;
        logic            fb;
        r = crc;
        for (int i = ByteW - 1; i >= 0; i--) begin
            fb = r[CrcW-1] ^ d[i];
            r  = {r[CrcW-2:0], 1'b0};
            if (fb) begin
                r = r ^ CrcPoly;
            end
        end
        return r;
    endfunction

    task automatic emit_byte(input logic [7:0] d, input logic fold, input logic fe,
                             inout int n);
        t_frame_byte e;
        if (fold) begin
            crc_run = crc_ccitt_byte(crc_run, d);
        end
        e.data = d;
        e.b    = fe;
        frame_bytes_q.push_back(e);
        n++;
    endtask

    task automatic emit_crc(inout int n);
        logic [CrcW-1:0] c;
        c = crc_run;
        emit_byte(c[7:0], 1'b0, 1'b0, n);
        emit_byte(c[15:8], 1'b0, 1'b1, n);
        in_frame = 1'b0;
        crc_run  = CrcInit;
    endtask

    task automatic emit_payload(input logic [7:0] d, inout int n);
        emit_byte(d, 1'b1, 1'b0, n);
        bytes_left = bytes_left - LenW'(1);
        if (bytes_left == '0) begin
            emit_crc(n);
        end
    endtask

    // Append the bytes that one accepted request produces
    task automatic serialize_item(input logic st, input logic [7:0] ty,
                                  input logic [6:0] ln, input logic [7:0] db,
                                  output int n);
        logic [6:0]      plen;
        logic [SeqW-1:0] s;
        n = 0;
        if (st) begin
            plen = (int'(ln) > MaxPayload) ? 7'(MaxPayload) : ln;
            if (in_frame) begin
                frames_cut++;
            end
            frames_opened++;
            if (int'(plen) > longest_len) begin
                longest_len = int'(plen);
            end
            s        = seq_next;
            seq_next = seq_next + SeqW'(1);
            crc_run  = CrcInit;
            emit_byte(MagicA, 1'b0, 1'b0, n);
            emit_byte(MagicB, 1'b0, 1'b0, n);
            emit_byte(ProtoVer, 1'b1, 1'b0, n);
            emit_byte(ty, 1'b1, 1'b0, n);
            emit_byte(s[7:0], 1'b1, 1'b0, n);
            emit_byte(s[15:8], 1'b1, 1'b0, n);
            emit_byte({1'b0, plen}, 1'b1, 1'b0, n);
            emit_byte(8'h00, 1'b1, 1'b0, n);
            if (plen == '0) begin
                bytes_left = '0;
                emit_crc(n);
            end else begin
                in_frame   = 1'b1;
                bytes_left = plen;
                emit_payload(db, n);
            end
        end else if (in_frame && bytes_left != '0) begin
            emit_payload(db, n);
        end else begin
            dropped_items++;
        end
    endtask

    // Offer one request in bursts with random gaps; predict once it is taken
    task automatic offer_request(input logic st, input logic [7:0] ty,
                                 input logic [6:0] ln, input logic [7:0] db,
                                 output int n);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = int'($urandom_range(1, 24));
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_start_req   <= st;
        i_msg_type    <= ty;
        i_payload_len <= ln;
        i_data_byte   <= db;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        serialize_item(st, ty, ln, db, n);
        if (n != 0) begin
            busy_items++;
        end
    endtask

    // Output side: stall pattern follows rx_cyc[8:6], plus two long hold-offs
    always @(posedge i_clk) begin
        rx_cyc = rx_cyc + 32'd1;
        if (hold_cnt == 0 && hold_step < 2 &&
            busy_items >= ((hold_step == 0) ? 100 : 260)) begin
            hold_cnt  = 300;
            hold_step = hold_step + 1;
        end
        if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
            i_ready <= 1'b0;
        end else begin
            case (rx_cyc[8:6])
                3'd2:    i_ready <= 1'($urandom_range(0, 1));
                3'd3:    i_ready <= (rx_cyc[1:0] != 2'd3);
                3'd4:    i_ready <= ($urandom_range(0, 7) != 0);
                3'd5:    i_ready <= ((rx_cyc % 7) < 2);
                3'd7:    i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin : out_check
        t_frame_byte want;
        if (i_rst_n && o_valid === 1'b1 && i_ready === 1'b1) begin
            bytes_checked++;
            if (frame_bytes_q.size() == 0) begin
                out_errors++;
                $display("%0t: unexpected byte: expected none, actual %02h end %0b",
                         $time, o_out_byte, o_frame_end);
            end else begin
                want = frame_bytes_q.pop_front();
                if (o_out_byte !== want.data) begin
                    out_errors++;
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, o_out_byte);
                end
                if (o_frame_end !== want.b) begin
                    out_errors++;
                    $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                             $time, want.b, o_frame_end);
                end
            end
        end
    end

    // Abort when neither side moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("crc16_frame_builder_core regression: fail");
                $finish;
            end
        end
    end

    initial begin
        int         n;
        int         kind;
        int         pick;
        int         cut;
        int         plen;
        logic [6:0] ln;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            offer_request(dir_rows[r].start, dir_rows[r].mtype, dir_rows[r].len,
                          dir_rows[r].data, n);
            if (dir_rows[r].chk_n && n != int'(dir_rows[r].n_res)) begin
                tbl_errors++;
                $display("%0t: row %0d byte count: expected %0d, actual %0d",
                         $time, r, dir_rows[r].n_res, n);
            end
        end

        // Mostly whole frames with random content, some cut short, some stray bytes
        while (busy_items < ItemTarget) begin
            kind = int'($urandom_range(0, 99));
            if (kind < 90) begin
                pick = int'($urandom_range(0, 9));
                ln   = (pick < 7) ? 7'($urandom_range(0, 8)) :
                       (pick < 9) ? 7'($urandom_range(9, 40)) : 7'($urandom_range(0, 127));
                plen = (int'(ln) > MaxPayload) ? MaxPayload : int'(ln);
                cut  = (kind < 80 || plen < 2) ? plen - 1 :
                       int'($urandom_range(0, plen - 2));
                offer_request(1'b1, 8'($urandom_range(0, 255)), ln,
                              8'($urandom_range(0, 255)), n);
                for (int j = 0; j < cut; j++) begin
                    offer_request(1'b0, 8'($urandom_range(0, 255)),
                                  7'($urandom_range(0, 127)),
                                  8'($urandom_range(0, 255)), n);
                end
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    offer_request(1'b0, 8'($urandom_range(0, 255)),
                                  7'($urandom_range(0, 127)),
                                  8'($urandom_range(0, 255)), n);
                end
            end
        end
        i_valid <= 1'b0;

        while (frame_bytes_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d frames (%0d abandoned, longest payload %0d), %0d stray bytes",
                 frames_opened, frames_cut, longest_len, dropped_items);
        $display("checked %0d output bytes from %0d requests with effect",
                 bytes_checked, busy_items);
        if (out_errors == 0 && tbl_errors == 0) begin
            $display("crc16_frame_builder_core regression: pass");
        end else begin
            $display("crc16_frame_builder_core regression: fail");
        end
        $finish;
    end

endmodule
